// File: rtl/sed_pkg.sv
// Shared types and constants for the string escape decoder.
package sed_pkg;

    // Reset value of the delimiter register (double quote).
    localparam logic [7:0] DELIM_RESET = 8'h22;

    // Defaults for the top-level parameters.
    localparam int BUFFER_LENGTH_DEF = 512;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Character codes that the decoder recognizes.
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_BSPACE  = 8'h08;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_CRET    = 8'h0D;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_END     = 2'd1,
        ST_NEWLINE = 2'd2,
        ST_LONG    = 2'd3
    } status_t;

    // Decoder mode, one-hot.
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESCAPE = 3'b010,
        MODE_DIGITS = 3'b100
    } mode_t;

    // One queue entry: the one or two results caused by one input item.
    typedef struct packed {
        logic       two;
        logic [7:0] value0;
        status_t    status0;
        logic [7:0] value1;
        status_t    status1;
    } sed_entry_t;

endpackage

// File: rtl/string_escape_decoder.sv
// Top level: a decoded result passes the entry queue, then the m_* output register.
// Throughput: one item per cycle unless the queue is full; an item with two results
// holds the single output register for each in turn; the queue absorbs the difference.
// Reset (aresetn low, synchronous) returns to normal mode with an empty count,
// sets the delimiter to a double quote and empties the queue.
// Latency and rate are set by the queue write and the output register.
module string_escape_decoder #(
    parameter int BUFFER_LENGTH = sed_pkg::BUFFER_LENGTH_DEF,
    parameter int QUEUE_DEPTH   = sed_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_value
    output logic [1:0] m_tuser,   // [1:0] status
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data   // [7:0] delimiter
);
    import sed_pkg::*;

    logic       q_full, q_push, q_empty, q_pop;
    sed_entry_t q_entry, q_head;

    // Byte classification and escape state.
    sed_front #(
        .BUFFER_LENGTH(BUFFER_LENGTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // Entry queue between front and back.
    sed_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Result delivery.
    sed_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// File: rtl/sed_front.sv
// Front end: accepts text bytes, tracks escape state and classifies results.
module sed_front #(
    parameter int BUFFER_LENGTH = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               q_full,
    output logic               q_push,
    output sed_pkg::sed_entry_t q_entry
);
    import sed_pkg::*;

    localparam int CW = $clog2(BUFFER_LENGTH);
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(BUFFER_LENGTH - 1);

    mode_t         mode_reg, mode_next;
    logic [7:0]    oct_reg, oct_next;
    logic [1:0]    digits_reg, digits_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    delim_reg;

    logic          accept;
    logic          is_digit;
    logic [7:0]    oct_step;
    logic          plain_run;
    logic          plain_slot1;
    logic [CW-1:0] cnt_base;
    logic          p_valid;
    logic [7:0]    p_value;
    status_t       p_status;
    sed_entry_t    ent;
    logic          slot0_valid;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;

    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    // Digit escape accumulation; only the low byte is ever reported.
    assign oct_step = {oct_reg[4:0], 3'b000} + {4'b0000, s_tdata[3:0]};

    // Mode-dependent handling of the byte, then the normal-mode handling.
    always_comb begin
        mode_next   = mode_reg;
        oct_next    = oct_reg;
        digits_next = digits_reg;
        cnt_base    = count_reg;
        count_next  = count_reg;
        plain_run   = 1'b0;
        plain_slot1 = 1'b0;
        slot0_valid = 1'b0;
        ent         = '0;
        p_valid     = 1'b0;
        p_value     = 8'h00;
        p_status    = ST_DATA;

        unique case (mode_reg)
            MODE_ESCAPE: begin
                mode_next   = MODE_NORMAL;
                slot0_valid = 1'b1;
                ent.status0 = ST_DATA;
                case (s_tdata)
                    CH_BSLASH:  ent.value0 = CH_BSLASH;
                    CH_LOWER_N: ent.value0 = CH_NEWLINE;
                    CH_LOWER_T: ent.value0 = CH_TAB;
                    CH_LOWER_B: ent.value0 = CH_BSPACE;
                    CH_LOWER_F: ent.value0 = CH_FFEED;
                    CH_LOWER_R: ent.value0 = CH_CRET;
                    default: begin
                        if (is_digit) begin
                            slot0_valid = 1'b0;
                            oct_next    = {4'b0000, s_tdata[3:0]};
                            digits_next = 2'd1;
                            mode_next   = MODE_DIGITS;
                        end else begin
                            ent.value0 = s_tdata;
                        end
                    end
                endcase
                if (slot0_valid) begin
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_DIGITS: begin
                if (is_digit) begin
                    oct_next    = oct_step;
                    digits_next = digits_reg + 2'd1;
                    if (digits_reg == 2'd2) begin
                        slot0_valid = 1'b1;
                        ent.value0  = oct_step;
                        ent.status0 = ST_DATA;
                        count_next  = count_reg + CW'(1);
                        mode_next   = MODE_NORMAL;
                        oct_next    = 8'h00;
                        digits_next = 2'd0;
                    end
                end else begin
                    // A non-digit flushes the pending number, then is handled normally.
                    slot0_valid = 1'b1;
                    ent.value0  = oct_reg;
                    ent.status0 = ST_DATA;
                    cnt_base    = count_reg + CW'(1);
                    count_next  = cnt_base;
                    mode_next   = MODE_NORMAL;
                    oct_next    = 8'h00;
                    digits_next = 2'd0;
                    plain_run   = 1'b1;
                    plain_slot1 = 1'b1;
                end
            end
            default: begin
                plain_run = 1'b1;
            end
        endcase

        // Normal-mode handling of the byte.
        if (plain_run) begin
            if (s_tdata == delim_reg) begin
                p_valid     = 1'b1;
                p_status    = ST_END;
                mode_next   = MODE_NORMAL;
                oct_next    = 8'h00;
                digits_next = 2'd0;
                count_next  = '0;
            end else if (cnt_base >= COUNT_LIMIT) begin
                p_valid  = 1'b1;
                p_status = ST_LONG;
            end else if (s_tdata == CH_NEWLINE) begin
                p_valid  = 1'b1;
                p_status = ST_NEWLINE;
            end else if (s_tdata == CH_BSLASH) begin
                mode_next = MODE_ESCAPE;
            end else begin
                p_valid    = 1'b1;
                p_value    = s_tdata;
                p_status   = ST_DATA;
                count_next = cnt_base + CW'(1);
            end
        end

        // Place the normal-mode result in the first or second slot.
        if (plain_slot1) begin
            ent.two     = p_valid;
            ent.value1  = p_value;
            ent.status1 = p_status;
        end else if (plain_run) begin
            slot0_valid = p_valid;
            ent.value0  = p_value;
            ent.status0 = p_status;
        end
    end

    assign q_push  = accept && slot0_valid;
    assign q_entry = ent;

    // Decoder state, updated on each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            oct_reg    <= 8'h00;
            digits_reg <= 2'd0;
            count_reg  <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            oct_reg    <= oct_next;
            digits_reg <= digits_next;
            count_reg  <= count_next;
        end
    end

    // Delimiter configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            delim_reg <= cfg_data;
        end
    end

endmodule

// File: rtl/sed_queue.sv
// Short register queue of decoded entries between front and back.
module sed_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sed_pkg::sed_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output sed_pkg::sed_entry_t head
);
    import sed_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] NUM_FULL = NW'(DEPTH);

    sed_entry_t    store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] num_reg;
    logic          do_push, do_pop;

    assign full    = (num_reg == NUM_FULL);
    assign empty   = (num_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            num_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                num_reg <= num_reg + NW'(1);
            end else if (do_pop && !do_push) begin
                num_reg <= num_reg - NW'(1);
            end
        end
    end

endmodule

// File: rtl/sed_back.sv
// Back end: unpacks queue entries into single results on the output stream.
module sed_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  sed_pkg::sed_entry_t q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import sed_pkg::*;

    logic       valid_reg, valid_next;
    logic       phase_reg, phase_next;
    logic [7:0] data_reg, data_next;
    status_t    user_reg, user_next;
    logic       last_reg, last_next;
    logic       load_ok;

    assign load_ok = !valid_reg || m_tready;

    // Pick the next result: first slot of a two-result entry, or the final one.
    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load_ok) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                if (q_head.two && !phase_reg) begin
                    data_next  = q_head.value0;
                    user_next  = q_head.status0;
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end else begin
                    data_next  = phase_reg ? q_head.value1 : q_head.value0;
                    user_next  = phase_reg ? q_head.status1 : q_head.status0;
                    last_next  = 1'b1;
                    phase_next = 1'b0;
                    q_pop      = 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// File: rtl/sed_checker.sv
// Port-level checks for the string escape decoder, bound to the top level.
module sed_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);
    import sed_pkg::*;

    // Reset empties the output.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled item holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Markers carry a zero byte.
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_DATA) |-> (m_tdata == 8'h00))
        else $error("non-data result with nonzero byte");

    // Only a flushed number can precede another result of the same byte.
    a_first_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tuser == ST_DATA))
        else $error("non-final result is not data");

    // The end marker is always the final result of its byte.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_END) |-> m_tlast)
        else $error("end marker not last");

endmodule

bind string_escape_decoder sed_port_checks u_sed_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

// File: tb/sed_checker.sv
// Checker for the string escape decoder: predicts the decoded stream and compares it.
module sed_checker #(
    parameter int BUFFER_LENGTH = sed_pkg::BUFFER_LENGTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] byte_value
    input  logic [1:0] m_tuser,   // [1:0] status
    input  logic       m_tlast,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,  // [7:0] delimiter
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sed_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        status_t    status;
        logic       last;
    } decoded_t;

    // Shadow copy of the decoder state and its delimiter register.
    logic [7:0] delim_reg;
    mode_t      scan_mode;
    logic [9:0] digit_acc;
    logic [1:0] digit_cnt;
    logic [9:0] data_cnt;

    // Results owed by the block, oldest first.
    decoded_t   expected_q[$];
    decoded_t   step_out[2];
    int         step_len;
    int         errors;

    function automatic void emit(input logic [7:0] value, input status_t status);
        step_out[step_len] = '{value: value, status: status, last: 1'b0};
        step_len++;
    endfunction

    function automatic void emit_data(input logic [7:0] value);
        emit(value, ST_DATA);
        data_cnt = data_cnt + 10'd1;
    endfunction

    function automatic void clear_scan();
        scan_mode = MODE_NORMAL;
        digit_acc = '0;
        digit_cnt = '0;
        data_cnt  = '0;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // A byte seen outside any escape.
    function automatic void plain_byte(input logic [7:0] c);
        if (c == delim_reg) begin
            emit(8'h00, ST_END);
            clear_scan();
        end else if (data_cnt >= BUFFER_LENGTH - 1) begin
            emit(8'h00, ST_LONG);
        end else if (c == CH_NEWLINE) begin
            emit(8'h00, ST_NEWLINE);
        end else if (c == CH_BSLASH) begin
            scan_mode = MODE_ESCAPE;
        end else begin
            emit_data(c);
        end
    endfunction

    // The byte right after a backslash.
    function automatic void escaped_byte(input logic [7:0] c);
        scan_mode = MODE_NORMAL;
        case (c)
            CH_BSLASH:  emit_data(CH_BSLASH);
            CH_LOWER_N: emit_data(CH_NEWLINE);
            CH_LOWER_T: emit_data(CH_TAB);
            CH_LOWER_B: emit_data(CH_BSPACE);
            CH_LOWER_F: emit_data(CH_FFEED);
            CH_LOWER_R: emit_data(CH_CRET);
            default: begin
                if (is_digit(c)) begin
                    digit_acc = 10'(c - CH_ZERO);
                    digit_cnt = 2'd1;
                    scan_mode = MODE_DIGITS;
                end else begin
                    emit_data(c);
                end
            end
        endcase
    endfunction

    // A byte inside a numeric escape; a non-digit flushes the number first.
    function automatic void digit_byte(input logic [7:0] c);
        if (is_digit(c)) begin
            digit_acc = {digit_acc[6:0], 3'b000} + 10'(c - CH_ZERO);
            digit_cnt = digit_cnt + 2'd1;
            if (digit_cnt == 2'd3) begin
                emit_data(digit_acc[7:0]);
                scan_mode = MODE_NORMAL;
                digit_acc = '0;
                digit_cnt = '0;
            end
        end else begin
            emit_data(digit_acc[7:0]);
            scan_mode = MODE_NORMAL;
            digit_acc = '0;
            digit_cnt = '0;
            plain_byte(c);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] c);
        step_len = 0;
        case (scan_mode)
            MODE_ESCAPE: escaped_byte(c);
            MODE_DIGITS: digit_byte(c);
            default:     plain_byte(c);
        endcase
        if (step_len > 0) begin
            step_out[step_len - 1].last = 1'b1;
        end
        for (int i = 0; i < step_len; i++) begin
            expected_q.push_back(step_out[i]);
        end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function automatic void check_result();
        decoded_t exp_res;
        if (expected_q.size() == 0) begin
            $error("unexpected result: byte_value %0h status %0d last %0b",
                   m_tdata, m_tuser, m_tlast);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (m_tdata !== exp_res.value) begin
            $error("byte_value: expected %0h, actual %0h", exp_res.value, m_tdata);
            errors++;
        end
        if (m_tuser !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, m_tuser);
            errors++;
        end
        if (m_tlast !== exp_res.last) begin
            $error("last: expected %0b, actual %0b", exp_res.last, m_tlast);
            errors++;
        end
    endfunction

    // Watch the three channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg = DELIM_RESET;
            clear_scan();
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                delim_reg = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        pending    <= expected_q.size();
        fail_count <= errors;
    end

    initial begin
        errors = 0;
        delim_reg = DELIM_RESET;
        clear_scan();
    end

endmodule

// File: tb/tb_top.sv
// Top of the string escape decoder testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sed_pkg::*;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 80;

    // Opening sequence: field extremes, every escape letter, numeric escapes
    // of full length, cut short by a letter and cut short by the delimiter,
    // raw and escaped newline, escaped delimiter.
    localparam logic [7:0] INTRO [31] = '{
        8'h00, 8'hFF,
        CH_BSLASH, CH_LOWER_N, CH_BSLASH, CH_LOWER_T, CH_BSLASH, CH_LOWER_B,
        CH_BSLASH, CH_LOWER_F, CH_BSLASH, CH_LOWER_R, CH_BSLASH, CH_BSLASH,
        CH_BSLASH, CH_NINE, CH_NINE, CH_NINE,
        CH_BSLASH, 8'h31, 8'h78,
        CH_BSLASH, 8'h34, 8'h32, DELIM_RESET,
        CH_NEWLINE, CH_BSLASH, CH_NEWLINE,
        CH_BSLASH, DELIM_RESET, DELIM_RESET
    };

    localparam logic [7:0] ESCAPE_LETTERS [6] = '{
        CH_LOWER_N, CH_LOWER_T, CH_LOWER_B, CH_LOWER_F, CH_LOWER_R, CH_BSLASH
    };

    // Delimiters for the random phases: both extremes, a digit, the escape
    // character itself and a newline.
    localparam logic [7:0] PHASE_DELIM [5] = '{
        8'h00, 8'hFF, 8'h35, CH_BSLASH, CH_NEWLINE
    };

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] text_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] byte_value
    logic [1:0] m_tuser;    // [1:0] status
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;   // [7:0] delimiter

    int         fail_count;
    int         pending;
    bit         hold_req;
    logic [7:0] text_q[$];

    string_escape_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sed_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("string_escape_decoder regression: fail");
        $finish;
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] other_byte(input logic [7:0] delim);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == delim);
        return b;
    endfunction

    // One well-formed literal of random tokens, closed by the delimiter.
    task automatic add_literal(input logic [7:0] delim, input int ntok);
        int kind;
        int ndig;
        for (int t = 0; t < ntok; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                text_q.push_back(other_byte(delim));
            end else if (kind < 60) begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(ESCAPE_LETTERS[$urandom_range(0, 5)]);
            end else if (kind < 76) begin
                ndig = $urandom_range(1, 3);
                text_q.push_back(CH_BSLASH);
                repeat (ndig) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (kind < 84) begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 90) begin
                text_q.push_back(CH_NEWLINE);
            end else begin
                text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
        end
        text_q.push_back(delim);
    endtask

    // Fill the text buffer with literals and some raw noise.
    task automatic add_mix(input logic [7:0] delim, input int budget);
        while (text_q.size() < budget) begin
            if ($urandom_range(0, 99) < 85) begin
                add_literal(delim, $urandom_range(1, 12));
            end else begin
                repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Offer every buffered byte, one item per handshake.
    task automatic send_text(input bit steady);
        int gap;
        foreach (text_q[i]) begin
            s_tvalid <= 1'b1;
            s_tdata  <= text_q[i];
            do @(posedge aclk); while (!s_tready);
            gap = steady ? 0 : idle_gap();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        text_q.delete();
    endtask

    // Wait until every owed result has come, then let the pipeline settle.
    task automatic wait_idle();
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_delimiter(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random ready pattern, plus one long hold-off on request.
    initial begin : receiver
        int  gap;
        bit  hold_taken;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 60 : 6)) @(posedge aclk);
            gap = idle_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        logic [7:0] b;
        hold_req = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'h00;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening under the reset delimiter.
        foreach (INTRO[i]) text_q.push_back(INTRO[i]);
        send_text(1'b0);
        wait_idle();

        // Random phases, one per delimiter setting.
        foreach (PHASE_DELIM[p]) begin
            write_delimiter(PHASE_DELIM[p]);
            add_mix(PHASE_DELIM[p], PHASE_ITEMS);
            send_text($urandom_range(0, 3) == 0);
            wait_idle();
        end

        // Back to a double quote: one literal long enough to overflow the
        // buffer, sent while the receiver holds off.
        write_delimiter(DELIM_RESET);
        repeat (BUFFER_LENGTH_DEF + 3) begin
            do b = 8'($urandom_range(0, 255));
            while (b == DELIM_RESET || b == CH_BSLASH || b == CH_NEWLINE);
            text_q.push_back(b);
        end
        add_literal(DELIM_RESET, 30);
        add_mix(DELIM_RESET, text_q.size() + 30);
        hold_req = 1'b1;
        send_text(1'b0);
        wait_idle();

        // A last phase with a random delimiter.
        b = 8'($urandom_range(0, 255));
        write_delimiter(b);
        add_mix(b, 60);
        send_text(1'b0);
        wait_idle();

        if (fail_count == 0) begin
            $display("string_escape_decoder regression: pass");
        end else begin
            $display("string_escape_decoder regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sed_pkg.sv
rtl/sed_front.sv
rtl/sed_queue.sv
rtl/sed_back.sv
rtl/string_escape_decoder.sv
rtl/sed_checker.sv
tb/sed_checker.sv
tb/tb_top.sv
